@@ design/ccf_pkg.sv @@
// ccf_pkg: shared constants, types and helpers for the conic canonical form pipeline.
// Used by conic_canonical_form and ccf_div; depends on nothing else.
`default_nettype none

package ccf_pkg;

    // Number formats and iteration counts
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 64;
    localparam int DVD_W        = 64;
    localparam int DVS_W        = 34;

    localparam logic signed [31:0] K_Q30          = 32'sd652032874;
    localparam logic signed [31:0] QUARTER_PI_Q30 = 32'sd843314857;
    localparam logic signed [31:0] ANG_RND        = 32'sd1 <<< (29 - FRAC_BITS);
    localparam int                 ANG_SHIFT      = 30 - FRAC_BITS;

    // Pipeline stage positions (register index after the accepting edge)
    localparam int ST_PREP  = 1;
    localparam int ST_NRM_A = 2;
    localparam int ST_V0    = 3;
    localparam int ST_VEND  = ST_V0 + CORDIC_STEPS;
    localparam int ST_ANG   = ST_VEND + 1;
    localparam int ST_REND  = ST_ANG + CORDIC_STEPS;
    localparam int ST_M1    = ST_REND + 1;
    localparam int ST_M2    = ST_M1 + 1;
    localparam int ST_M3    = ST_M2 + 1;
    localparam int ST_M4    = ST_M3 + 1;
    localparam int ST_M5    = ST_M4 + 1;
    localparam int ST_Q     = ST_M5 + 1;
    localparam int ST_F1    = ST_Q + DIV_STEPS + 1;
    localparam int ST_F2    = ST_F1 + 1;
    localparam int VLD_LEN  = ST_F2 + 1;

    // Coefficients travelling beside the CORDIC units
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] e;
        logic signed [31:0] f;
        logic signed [31:0] ang;
        logic               bz;
        logic               eq;
    } t_lane;

    // Rebuilt coefficients travelling beside the dividers
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] e;
        logic signed [31:0] f;
        logic [16:0]        rot;
        logic               cmp_x;
        logic               cmp_y;
        logic               neg_cx;
        logic               neg_fx;
        logic               neg_cy;
        logic               neg_fy;
    } t_post;

    // atan(2^-i) in Q30
    function automatic logic signed [31:0] atan_q30(input int i);
        case (i)
            0:       return 32'sd843314857;
            1:       return 32'sd497837829;
            2:       return 32'sd263043837;
            3:       return 32'sd133525159;
            4:       return 32'sd67021687;
            5:       return 32'sd33543516;
            6:       return 32'sd16775851;
            7:       return 32'sd8388437;
            8:       return 32'sd4194283;
            9:       return 32'sd2097149;
            10:      return 32'sd1048576;
            11:      return 32'sd524288;
            12:      return 32'sd262144;
            13:      return 32'sd131072;
            14:      return 32'sd65536;
            15:      return 32'sd32768;
            16:      return 32'sd16384;
            17:      return 32'sd8192;
            18:      return 32'sd4096;
            19:      return 32'sd2048;
            20:      return 32'sd1024;
            21:      return 32'sd512;
            22:      return 32'sd256;
            23:      return 32'sd128;
            default: return 32'sd0;
        endcase
    endfunction

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

@@ design/ccf_div.sv @@
// ccf_div: unsigned restoring divider, one quotient bit per pipeline stage.
// Depends on ccf_pkg for the stage count and operand widths.
`default_nettype none

module ccf_div
    import ccf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic      [DVD_W-1:0] o_quotient
);

    // Dividend bits shift out the top while quotient bits shift in the bottom
    logic [DVD_W-1:0] r_num [0:DIV_STEPS-1];
    logic [DVS_W-1:0] r_rem [0:DIV_STEPS-1];
    logic [DVS_W-1:0] r_dvs [0:DIV_STEPS-1];

    for (genvar gk = 0; gk < DIV_STEPS; gk++) begin : g_st
        logic [DVD_W-1:0] w_num;
        logic [DVS_W-1:0] w_rem;
        logic [DVS_W-1:0] w_dvs;
        logic [DVS_W:0]   w_rs;
        logic             w_ge;

        if (gk == 0) begin : g_head
            assign w_num = i_dividend;
            assign w_rem = '0;
            assign w_dvs = i_divisor;
        end else begin : g_body
            assign w_num = r_num[gk-1];
            assign w_rem = r_rem[gk-1];
            assign w_dvs = r_dvs[gk-1];
        end

        // Trial subtract
        assign w_rs = {w_rem, w_num[DVD_W-1]};
        assign w_ge = (w_rs >= {1'b0, w_dvs});

        always_ff @(posedge i_clk) begin
            r_num[gk] <= {w_num[DVD_W-2:0], w_ge};
            r_rem[gk] <= w_ge ? DVS_W'(w_rs - {1'b0, w_dvs}) : w_rs[DVS_W-1:0];
            r_dvs[gk] <= w_dvs;
        end
    end

    assign o_quotient = r_num[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ design/conic_canonical_form.sv @@
// conic_canonical_form: principal-axis reduction of a conic, fully pipelined.
// Depends on ccf_pkg and ccf_div.
//
// Usage:
//   An input transaction is taken at a rising edge with start high and busy
//   low. busy stays low: the pipeline takes a new conic on every cycle.
//   Each result appears on the o_ ports for exactly one cycle, marked by
//   o_done. Results leave in input order, one per input.
//   Throughput is one conic per cycle. The path holds the input register,
//   a 3-stage normalize path, two 16-step CORDIC chains (vectoring then
//   rotation) with the angle stage between them, a 5-stage rebuild path, the
//   divider operand stage, the 64-stage bit-serial dividers used to complete
//   the squares and two final stages for signs, saturation and the swap.
//   The receiver cannot stall, so there is no back-pressure anywhere.
//   Reset clears the valid chain only; transactions in flight are dropped
//   and no o_done follows until new ones arrive.
`default_nettype none

module conic_canonical_form
    import ccf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_coef_xx,
    input  wire logic signed [31:0] i_coef_xy,
    input  wire logic signed [31:0] i_coef_yy,
    input  wire logic signed [31:0] i_coef_x,
    input  wire logic signed [31:0] i_coef_y,
    input  wire logic signed [31:0] i_coef_const,
    output logic                    o_done,
    output logic signed [31:0]      o_out_xx,
    output logic signed [31:0]      o_out_xy,
    output logic signed [31:0]      o_out_yy,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_const,
    output logic signed [16:0]      o_rot_angle,
    output logic                    o_axes_swapped,
    output logic signed [31:0]      o_centre_x,
    output logic signed [31:0]      o_centre_y
);

    assign busy = 1'b0;

    // Valid chain
    logic r_vld [0:VLD_LEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VLD_LEN; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start & ~busy;
            for (int k = 1; k < VLD_LEN; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Coefficient lane through CORDIC and rebuild
    t_lane r_lane [0:ST_M5];

    logic signed [31:0] w_ang;
    logic signed [31:0] w_ra, w_rb, w_rc, w_rd, w_re;

    for (genvar gk = 0; gk <= ST_M5; gk++) begin : g_lane
        if (gk == 0) begin : g_in
            always_ff @(posedge i_clk) begin
                r_lane[0].a   <= i_coef_xx;
                r_lane[0].b   <= i_coef_xy;
                r_lane[0].c   <= i_coef_yy;
                r_lane[0].d   <= i_coef_x;
                r_lane[0].e   <= i_coef_y;
                r_lane[0].f   <= i_coef_const;
                r_lane[0].ang <= '0;
                r_lane[0].bz  <= 1'b0;
                r_lane[0].eq  <= 1'b0;
            end
        end else if (gk == ST_PREP) begin : g_flags
            t_lane w_prep;
            always_comb begin
                w_prep    = r_lane[gk-1];
                w_prep.bz = (r_lane[gk-1].b == 32'sd0);
                w_prep.eq = (r_lane[gk-1].a == r_lane[gk-1].c);
            end
            always_ff @(posedge i_clk) begin
                r_lane[gk] <= w_prep;
            end
        end else if (gk == ST_ANG) begin : g_angle
            t_lane w_lang;
            always_comb begin
                w_lang     = r_lane[gk-1];
                w_lang.ang = w_ang;
            end
            always_ff @(posedge i_clk) begin
                r_lane[gk] <= w_lang;
            end
        end else if (gk == ST_M5) begin : g_rebuilt
            t_lane w_reb;
            always_comb begin
                w_reb   = r_lane[gk-1];
                w_reb.a = w_ra;
                w_reb.b = w_rb;
                w_reb.c = w_rc;
                w_reb.d = w_rd;
                w_reb.e = w_re;
            end
            always_ff @(posedge i_clk) begin
                r_lane[gk] <= w_reb;
            end
        end else begin : g_copy
            always_ff @(posedge i_clk) begin
                r_lane[gk] <= r_lane[gk-1];
            end
        end
    end

    // Vectoring start vector (|A-C|, B*sign(A-C)) and its larger magnitude
    logic signed [31:0] w0_a, w0_b, w0_c;
    logic signed [32:0] w_diff, w_px, w_py, w_pya;
    logic signed [45:0] r_px, r_py;
    logic [40:0]        r_pm;

    assign w0_a   = r_lane[0].a;
    assign w0_b   = r_lane[0].b;
    assign w0_c   = r_lane[0].c;
    assign w_diff = 33'(w0_a) - 33'(w0_c);
    assign w_px   = w_diff[32] ? -w_diff : w_diff;
    assign w_py   = w_diff[32] ? -33'(w0_b) : 33'(w0_b);
    assign w_pya  = w_py[32] ? -w_py : w_py;

    always_ff @(posedge i_clk) begin
        r_px <= 46'(w_px);
        r_py <= 46'(w_py);
        r_pm <= (w_px > w_pya) ? 41'(w_px) : 41'(w_pya);
    end

    // Normalize so the larger magnitude reaches 2^40 (coarse then fine shifts)
    logic [40:0]        w_na_m, w_nb_m, r_nm;
    logic signed [45:0] w_na_x, w_na_y, w_nb_x, w_nb_y, r_nx, r_ny;

    always_comb begin
        w_na_m = r_pm;
        w_na_x = r_px;
        w_na_y = r_py;
        for (int s = 32; s >= 8; s = s >> 1) begin
            if (w_na_m < (41'd1 << (41 - s))) begin
                w_na_m = w_na_m << s;
                w_na_x = w_na_x <<< s;
                w_na_y = w_na_y <<< s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nm <= w_na_m;
        r_nx <= w_na_x;
        r_ny <= w_na_y;
    end

    always_comb begin
        w_nb_m = r_nm;
        w_nb_x = r_nx;
        w_nb_y = r_ny;
        for (int s = 4; s >= 1; s = s >> 1) begin
            if (w_nb_m < (41'd1 << (41 - s))) begin
                w_nb_m = w_nb_m << s;
                w_nb_x = w_nb_x <<< s;
                w_nb_y = w_nb_y <<< s;
            end
        end
    end

    // Vectoring CORDIC, one micro-rotation per stage
    logic signed [45:0] r_vx [0:CORDIC_STEPS];
    logic signed [45:0] r_vy [0:CORDIC_STEPS];
    logic signed [31:0] r_vz [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        r_vx[0] <= w_nb_x;
        r_vy[0] <= w_nb_y;
        r_vz[0] <= '0;
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_vec
        logic signed [45:0] w_xs, w_ys;
        assign w_xs = r_vx[gi] >>> gi;
        assign w_ys = r_vy[gi] >>> gi;
        always_ff @(posedge i_clk) begin
            if (!r_vy[gi][45]) begin
                r_vx[gi+1] <= r_vx[gi] + w_ys;
                r_vy[gi+1] <= r_vy[gi] - w_xs;
                r_vz[gi+1] <= r_vz[gi] + atan_q30(gi);
            end else begin
                r_vx[gi+1] <= r_vx[gi] - w_ys;
                r_vy[gi+1] <= r_vy[gi] + w_xs;
                r_vz[gi+1] <= r_vz[gi] - atan_q30(gi);
            end
        end
    end

    // Half angle; zero when there is no cross term, else pi/4 when A equals C
    always_comb begin
        if (r_lane[ST_VEND].bz) begin
            w_ang = '0;
        end else if (r_lane[ST_VEND].eq) begin
            w_ang = QUARTER_PI_Q30;
        end else begin
            w_ang = r_vz[CORDIC_STEPS] >>> 1;
        end
    end

    // Rotation CORDIC gives cos and sin in Q30
    logic signed [31:0] r_rx [0:CORDIC_STEPS];
    logic signed [31:0] r_ry [0:CORDIC_STEPS];
    logic signed [31:0] r_rz [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        r_rx[0] <= K_Q30;
        r_ry[0] <= '0;
        r_rz[0] <= w_ang;
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_rot
        logic signed [31:0] w_xs, w_ys;
        assign w_xs = r_rx[gi] >>> gi;
        assign w_ys = r_ry[gi] >>> gi;
        always_ff @(posedge i_clk) begin
            if (!r_rz[gi][31]) begin
                r_rx[gi+1] <= r_rx[gi] - w_ys;
                r_ry[gi+1] <= r_ry[gi] + w_xs;
                r_rz[gi+1] <= r_rz[gi] - atan_q30(gi);
            end else begin
                r_rx[gi+1] <= r_rx[gi] + w_ys;
                r_ry[gi+1] <= r_ry[gi] - w_xs;
                r_rz[gi+1] <= r_rz[gi] + atan_q30(gi);
            end
        end
    end

    // M1: squares and cross product of cos and sin
    logic signed [63:0] r_pcc, r_pss, r_pcs;
    logic signed [31:0] r_co1, r_si1;

    always_ff @(posedge i_clk) begin
        r_pcc <= r_rx[CORDIC_STEPS] * r_rx[CORDIC_STEPS];
        r_pss <= r_ry[CORDIC_STEPS] * r_ry[CORDIC_STEPS];
        r_pcs <= r_rx[CORDIC_STEPS] * r_ry[CORDIC_STEPS];
        r_co1 <= r_rx[CORDIC_STEPS];
        r_si1 <= r_ry[CORDIC_STEPS];
    end

    // M2: round to Q30, form cc-ss, 2cs and C-A
    logic signed [31:0] w_cc, w_ss, w_cs;
    logic signed [31:0] r_cc, r_ss, r_cs, r_co2, r_si2;
    logic signed [32:0] r_cms, r_cs2, r_cma;
    logic signed [31:0] w1_a, w1_c;

    assign w_cc = 32'((r_pcc + 64'sd536870912) >>> 30);
    assign w_ss = 32'((r_pss + 64'sd536870912) >>> 30);
    assign w_cs = 32'((r_pcs + 64'sd536870912) >>> 30);
    assign w1_a = r_lane[ST_M1].a;
    assign w1_c = r_lane[ST_M1].c;

    always_ff @(posedge i_clk) begin
        r_cc  <= w_cc;
        r_ss  <= w_ss;
        r_cs  <= w_cs;
        r_cms <= 33'(w_cc) - 33'(w_ss);
        r_cs2 <= 33'(w_cs) <<< 1;
        r_cma <= 33'(w1_c) - 33'(w1_a);
        r_co2 <= r_co1;
        r_si2 <= r_si1;
    end

    // M3: the partial products of the rebuilt coefficients
    logic signed [31:0] w2_a, w2_b, w2_c, w2_d, w2_e;
    logic signed [67:0] r_pacc, r_pcss, r_pbcs, r_pass, r_pccc, r_pcab, r_pbms;
    logic signed [67:0] r_pdco, r_pesi, r_peco, r_pdsi;

    assign w2_a = r_lane[ST_M2].a;
    assign w2_b = r_lane[ST_M2].b;
    assign w2_c = r_lane[ST_M2].c;
    assign w2_d = r_lane[ST_M2].d;
    assign w2_e = r_lane[ST_M2].e;

    always_ff @(posedge i_clk) begin
        r_pacc <= 68'(w2_a * 64'(r_cc));
        r_pcss <= 68'(w2_c * 64'(r_ss));
        r_pbcs <= 68'(w2_b * 64'(r_cs));
        r_pass <= 68'(w2_a * 64'(r_ss));
        r_pccc <= 68'(w2_c * 64'(r_cc));
        r_pcab <= 68'(r_cma) * 68'(r_cs2);
        r_pbms <= 68'(w2_b) * 68'(r_cms);
        r_pdco <= 68'(w2_d * 64'(r_co2));
        r_pesi <= 68'(w2_e * 64'(r_si2));
        r_peco <= 68'(w2_e * 64'(r_co2));
        r_pdsi <= 68'(w2_d * 64'(r_si2));
    end

    // M4: sum and round back to Q16.16
    logic signed [39:0] r_sa, r_sb, r_sc, r_sd, r_se;

    always_ff @(posedge i_clk) begin
        r_sa <= 40'((r_pacc + r_pcss + r_pbcs + 68'sd536870912) >>> 30);
        r_sc <= 40'((r_pass + r_pccc - r_pbcs + 68'sd536870912) >>> 30);
        r_sb <= 40'((r_pcab + r_pbms + 68'sd536870912) >>> 30);
        r_sd <= 40'((r_pdco + r_pesi + 68'sd536870912) >>> 30);
        r_se <= 40'((r_peco - r_pdsi + 68'sd536870912) >>> 30);
    end

    // M5: saturate, or pass the input through when there is no cross term
    logic w4_bz;
    assign w4_bz = r_lane[ST_M4].bz;
    assign w_ra  = w4_bz ? r_lane[ST_M4].a : sat32(68'(r_sa));
    assign w_rb  = w4_bz ? r_lane[ST_M4].b : sat32(68'(r_sb));
    assign w_rc  = w4_bz ? r_lane[ST_M4].c : sat32(68'(r_sc));
    assign w_rd  = w4_bz ? r_lane[ST_M4].d : sat32(68'(r_sd));
    assign w_re  = w4_bz ? r_lane[ST_M4].e : sat32(68'(r_se));

    // Q: divider operands for completing both squares
    logic signed [31:0] w5_a, w5_c, w5_d, w5_e, w5_ang, w_rnd_ang;
    logic [32:0]        w_abs_a, w_abs_c, w_abs_d, w_abs_e;
    logic [DVD_W-1:0]   r_dvd_cx, r_dvd_fx, r_dvd_cy, r_dvd_fy;
    logic [DVS_W-1:0]   r_dvs_cx, r_dvs_fx, r_dvs_cy, r_dvs_fy;
    t_post              r_post [0:DIV_STEPS];

    assign w5_a      = r_lane[ST_M5].a;
    assign w5_c      = r_lane[ST_M5].c;
    assign w5_d      = r_lane[ST_M5].d;
    assign w5_e      = r_lane[ST_M5].e;
    assign w5_ang    = r_lane[ST_M5].ang;
    assign w_abs_a   = w5_a[31] ? 33'(-33'(w5_a)) : 33'(w5_a);
    assign w_abs_c   = w5_c[31] ? 33'(-33'(w5_c)) : 33'(w5_c);
    assign w_abs_d   = w5_d[31] ? 33'(-33'(w5_d)) : 33'(w5_d);
    assign w_abs_e   = w5_e[31] ? 33'(-33'(w5_e)) : 33'(w5_e);
    assign w_rnd_ang = (w5_ang + ANG_RND) >>> ANG_SHIFT;

    always_ff @(posedge i_clk) begin
        r_dvd_cx <= DVD_W'(w_abs_d) << FRAC_BITS;
        r_dvd_cy <= DVD_W'(w_abs_e) << FRAC_BITS;
        r_dvd_fx <= DVD_W'(w_abs_d) * DVD_W'(w_abs_d);
        r_dvd_fy <= DVD_W'(w_abs_e) * DVD_W'(w_abs_e);
        r_dvs_cx <= DVS_W'({w_abs_a, 1'b0});
        r_dvs_cy <= DVS_W'({w_abs_c, 1'b0});
        r_dvs_fx <= DVS_W'({w_abs_a, 2'b00});
        r_dvs_fy <= DVS_W'({w_abs_c, 2'b00});

        r_post[0].a      <= w5_a;
        r_post[0].b      <= r_lane[ST_M5].b;
        r_post[0].c      <= w5_c;
        r_post[0].d      <= w5_d;
        r_post[0].e      <= w5_e;
        r_post[0].f      <= r_lane[ST_M5].f;
        r_post[0].rot    <= w_rnd_ang[16:0];
        r_post[0].cmp_x  <= (w5_a != 32'sd0) && (w5_d != 32'sd0);
        r_post[0].cmp_y  <= (w5_c != 32'sd0) && (w5_e != 32'sd0);
        r_post[0].neg_cx <= w5_d[31] ^ w5_a[31];
        r_post[0].neg_fx <= w5_a[31];
        r_post[0].neg_cy <= w5_e[31] ^ w5_c[31];
        r_post[0].neg_fy <= w5_c[31];

        // Lane beside the dividers
        for (int k = 1; k <= DIV_STEPS; k++) begin
            r_post[k] <= r_post[k-1];
        end
    end

    logic [DVD_W-1:0] w_q_cx, w_q_fx, w_q_cy, w_q_fy;

    ccf_div u_div_cx (.i_clk(i_clk), .i_dividend(r_dvd_cx), .i_divisor(r_dvs_cx),
                      .o_quotient(w_q_cx));
    ccf_div u_div_fx (.i_clk(i_clk), .i_dividend(r_dvd_fx), .i_divisor(r_dvs_fx),
                      .o_quotient(w_q_fx));
    ccf_div u_div_cy (.i_clk(i_clk), .i_dividend(r_dvd_cy), .i_divisor(r_dvs_cy),
                      .o_quotient(w_q_cy));
    ccf_div u_div_fy (.i_clk(i_clk), .i_dividend(r_dvd_fy), .i_divisor(r_dvs_fy),
                      .o_quotient(w_q_fy));

    // F1: apply signs, centres, reduced constant kept wide
    t_post              w_pe;
    t_post              w_f1;
    logic signed [67:0] w_qcx, w_qfx, w_qcy, w_qfy, w_fsx, w_fsy;
    t_post              r_f1;
    logic signed [31:0] r_f1_cx, r_f1_cy;
    logic signed [67:0] r_f1_fw;

    assign w_pe  = r_post[DIV_STEPS];
    assign w_qcx = $signed({4'b0, w_q_cx});
    assign w_qfx = $signed({4'b0, w_q_fx});
    assign w_qcy = $signed({4'b0, w_q_cy});
    assign w_qfy = $signed({4'b0, w_q_fy});
    assign w_fsx = w_pe.cmp_x ? (w_pe.neg_fx ? -w_qfx : w_qfx) : 68'sd0;
    assign w_fsy = w_pe.cmp_y ? (w_pe.neg_fy ? -w_qfy : w_qfy) : 68'sd0;

    // Completed axes lose their linear term
    always_comb begin
        w_f1 = w_pe;
        if (w_pe.cmp_x) begin
            w_f1.d = '0;
        end
        if (w_pe.cmp_y) begin
            w_f1.e = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1    <= w_f1;
        r_f1_cx <= w_pe.cmp_x ? sat32(w_pe.neg_cx ? w_qcx : -w_qcx) : 32'sd0;
        r_f1_cy <= w_pe.cmp_y ? sat32(w_pe.neg_cy ? w_qcy : -w_qcy) : 32'sd0;
        r_f1_fw <= 68'(w_pe.f) - w_fsx - w_fsy;
    end

    // F2: final saturation and axis swap into the output registers
    logic signed [31:0] w6_a, w6_c;
    logic               w_swap;
    logic signed [31:0] r_xx, r_xy, r_yy, r_x, r_y, r_cst, r_cx, r_cy;
    logic signed [16:0] r_rot;
    logic               r_swp;

    assign w6_a   = r_f1.a;
    assign w6_c   = r_f1.c;
    assign w_swap = (w6_a > w6_c);

    always_ff @(posedge i_clk) begin
        r_xx  <= w_swap ? w6_c : w6_a;
        r_yy  <= w_swap ? w6_a : w6_c;
        r_x   <= w_swap ? r_f1.e : r_f1.d;
        r_y   <= w_swap ? r_f1.d : r_f1.e;
        r_xy  <= r_f1.b;
        r_cst <= sat32(r_f1_fw);
        r_rot <= $signed(r_f1.rot);
        r_swp <= w_swap;
        r_cx  <= r_f1_cx;
        r_cy  <= r_f1_cy;
    end

    assign o_done         = r_vld[ST_F2];
    assign o_out_xx       = r_xx;
    assign o_out_xy       = r_xy;
    assign o_out_yy       = r_yy;
    assign o_out_x        = r_x;
    assign o_out_y        = r_y;
    assign o_out_const    = r_cst;
    assign o_rot_angle    = r_rot;
    assign o_axes_swapped = r_swp;
    assign o_centre_x     = r_cx;
    assign o_centre_y     = r_cy;

`ifndef SYNTHESIS
    // A result only follows a transaction taken the full latency earlier
    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, ST_F2 + 1))
        else $error("result without matching input transaction");

    // After the swap the x squared term never exceeds the y squared term
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out_xx <= o_out_yy))
        else $error("canonical quadratic terms out of order");

    // Both centres set means both linear terms were cleared
    a_both_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_centre_x != 32'sd0) && (o_centre_y != 32'sd0))
        |-> ((o_out_x == 32'sd0) && (o_out_y == 32'sd0)))
        else $error("linear term left after completing both squares");
`endif

endmodule

`default_nettype wire

@@ tb/conic_canonical_form_checker.sv @@
// conic_canonical_form_checker: watches the input and result channels of the
// conic reduction block, predicts each result and compares it field by field.
// Depends on nothing but the block's port widths.

module conic_canonical_form_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] i_coef_xx,
    input  logic signed [31:0] i_coef_xy,
    input  logic signed [31:0] i_coef_yy,
    input  logic signed [31:0] i_coef_x,
    input  logic signed [31:0] i_coef_y,
    input  logic signed [31:0] i_coef_const,
    input  logic               o_done,
    input  logic signed [31:0] o_out_xx,
    input  logic signed [31:0] o_out_xy,
    input  logic signed [31:0] o_out_yy,
    input  logic signed [31:0] o_out_x,
    input  logic signed [31:0] o_out_y,
    input  logic signed [31:0] o_out_const,
    input  logic signed [16:0] o_rot_angle,
    input  logic               o_axes_swapped,
    input  logic signed [31:0] o_centre_x,
    input  logic signed [31:0] o_centre_y,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int FRAC      = 16;
    localparam int STEPS     = 16;
    localparam longint K_VAL = 64'sd652032874;
    localparam longint QPI   = 64'sd843314857;

    typedef struct packed {
        logic signed [31:0] xx;
        logic signed [31:0] xy;
        logic signed [31:0] yy;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] cst;
        logic signed [16:0] rot;
        logic               swp;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } t_canon;

    t_canon canon_q[$];
    longint atan_tab[24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128};

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Vectoring CORDIC: angle of (vx, vy) in Q30
    function automatic longint vec_angle(longint vx, longint vy);
        longint m, z, xs, ys;
        m = (vy < 0) ? -vy : vy;
        if (vx > m) m = vx;
        z = 0;
        while (m < (64'sd1 <<< 40)) begin
            m = m * 2; vx = vx * 2; vy = vy * 2;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx += ys; vy -= xs; z += atan_tab[i];
            end else begin
                vx -= ys; vy += xs; z -= atan_tab[i];
            end
        end
        return z;
    endfunction

    function automatic t_canon reduce_conic(longint a, longint b, longint c,
                                            longint d, longint e, longint f);
        t_canon r;
        longint ang, cx, cy, t, co, si, z, xs, ys, cc, ss, cs, vx, vy;
        longint na, nb, nc, nd, ne;
        bit swp;
        ang = 0; cx = 0; cy = 0; swp = 0;
        if (b != 0) begin
            if (a == c) begin
                ang = QPI;
            end else begin
                vx = a - c;
                vy = b;
                if (vx < 0) begin
                    vx = -vx; vy = -vy;
                end
                ang = vec_angle(vx, vy) >>> 1;
            end
            // rotation CORDIC for cos and sin
            co = K_VAL; si = 0; z = ang;
            for (int i = 0; i < STEPS; i++) begin
                xs = co >>> i;
                ys = si >>> i;
                if (z >= 0) begin
                    co -= ys; si += xs; z -= atan_tab[i];
                end else begin
                    co += ys; si -= xs; z += atan_tab[i];
                end
            end
            cc = round_q30(co * co);
            ss = round_q30(si * si);
            cs = round_q30(co * si);
            na = clamp32(round_q30(a * cc + c * ss + b * cs));
            nc = clamp32(round_q30(a * ss + c * cc - b * cs));
            nb = clamp32(round_q30((c - a) * (2 * cs) + b * (cc - ss)));
            nd = clamp32(round_q30(d * co + e * si));
            ne = clamp32(round_q30(e * co - d * si));
            a = na; b = nb; c = nc; d = nd; e = ne;
        end
        // complete the square per axis (division truncates toward zero)
        if (a != 0 && d != 0) begin
            cx = clamp32(-((d * (64'sd1 <<< FRAC)) / (2 * a)));
            f -= (d * d) / (4 * a);
            d = 0;
        end
        if (c != 0 && e != 0) begin
            cy = clamp32(-((e * (64'sd1 <<< FRAC)) / (2 * c)));
            f -= (e * e) / (4 * c);
            e = 0;
        end
        f = clamp32(f);
        if (a > c) begin
            t = a; a = c; c = t;
            t = d; d = e; e = t;
            swp = 1;
        end
        r.xx = a[31:0]; r.xy = b[31:0]; r.yy = c[31:0];
        r.x = d[31:0]; r.y = e[31:0]; r.cst = f[31:0];
        t = (ang + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
        r.rot = t[16:0];
        r.swp = swp;
        r.cx = cx[31:0]; r.cy = cy[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Predict on each accepted transaction, compare on each strobe
    always @(posedge i_clk) begin
        t_canon want;
        if (i_rst_n && start && !busy) begin
            canon_q.push_back(reduce_conic(i_coef_xx, i_coef_xy, i_coef_yy,
                                           i_coef_x, i_coef_y, i_coef_const));
        end
        if (i_rst_n && o_done) begin
            if (canon_q.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = canon_q.pop_front();
                if (o_out_xx != want.xx) report_mismatch("out_xx", o_out_xx, want.xx);
                if (o_out_xy != want.xy) report_mismatch("out_xy", o_out_xy, want.xy);
                if (o_out_yy != want.yy) report_mismatch("out_yy", o_out_yy, want.yy);
                if (o_out_x != want.x) report_mismatch("out_x", o_out_x, want.x);
                if (o_out_y != want.y) report_mismatch("out_y", o_out_y, want.y);
                if (o_out_const != want.cst)
                    report_mismatch("out_const", o_out_const, want.cst);
                if (o_rot_angle != want.rot)
                    report_mismatch("rot_angle", o_rot_angle, want.rot);
                if (o_axes_swapped != want.swp)
                    report_mismatch("axes_swapped", o_axes_swapped, want.swp);
                if (o_centre_x != want.cx)
                    report_mismatch("centre_x", o_centre_x, want.cx);
                if (o_centre_y != want.cy)
                    report_mismatch("centre_y", o_centre_y, want.cy);
            end
        end
        o_pending = canon_q.size();
    end

endmodule

@@ tb/conic_canonical_form_test.sv @@
// conic_canonical_form_test: drives conics into the reduction block with random
// gaps and gives the verdict. Depends on conic_canonical_form and its checker.

module conic_canonical_form_test;

    localparam int LATENCY   = 108;
    localparam int N_RANDOM  = 800;
    localparam int CYCLE_MAX = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] coef_xx, coef_xy, coef_yy, coef_x, coef_y, coef_const;
    logic               o_done;
    logic signed [31:0] o_out_xx, o_out_xy, o_out_yy, o_out_x, o_out_y, o_out_const;
    logic signed [16:0] o_rot_angle;
    logic               o_axes_swapped;
    logic signed [31:0] o_centre_x, o_centre_y;
    int                 fail_count;
    int                 pending;
    int                 cycle_count;
    int                 idle_pct;

    conic_canonical_form uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_coef_xx(coef_xx), .i_coef_xy(coef_xy), .i_coef_yy(coef_yy),
        .i_coef_x(coef_x), .i_coef_y(coef_y), .i_coef_const(coef_const),
        .o_done(o_done), .o_out_xx(o_out_xx), .o_out_xy(o_out_xy),
        .o_out_yy(o_out_yy), .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_out_const(o_out_const), .o_rot_angle(o_rot_angle),
        .o_axes_swapped(o_axes_swapped), .o_centre_x(o_centre_x),
        .o_centre_y(o_centre_y)
    );

    conic_canonical_form_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_coef_xx(coef_xx), .i_coef_xy(coef_xy), .i_coef_yy(coef_yy),
        .i_coef_x(coef_x), .i_coef_y(coef_y), .i_coef_const(coef_const),
        .o_done(o_done), .o_out_xx(o_out_xx), .o_out_xy(o_out_xy),
        .o_out_yy(o_out_yy), .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_out_const(o_out_const), .o_rot_angle(o_rot_angle),
        .o_axes_swapped(o_axes_swapped), .o_centre_x(o_centre_x),
        .o_centre_y(o_centre_y), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_MAX) begin
                $display("[conic_canonical_form] ERROR");
                $finish;
            end
        end
    end

    // Random coefficient with a bias toward small, extreme and zero values
    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'h7fffffff;
            2:       return 32'h80000000;
            3, 4:    return $urandom;
            5:       return $urandom_range(0, 255) << 16;
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    // One transaction: optional gap, then hold start until accepted
    task automatic send_conic(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              logic [31:0] d, logic [31:0] e, logic [31:0] f);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        coef_xx <= a; coef_xy <= b; coef_yy <= c;
        coef_x <= d; coef_y <= e; coef_const <= f;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic random_conic();
        logic [31:0] a, b, c;
        a = pick_coef();
        b = pick_coef();
        c = ($urandom_range(0, 7) == 0) ? a : pick_coef();
        send_conic(a, b, c, pick_coef(), pick_coef(), pick_coef());
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        start = 1'b0;
        coef_xx = '0; coef_xy = '0; coef_yy = '0;
        coef_x = '0; coef_y = '0; coef_const = '0;
        idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: no cross term, equal diagonals, extremes, swap, completion
        send_conic(0, 0, 0, 0, 0, 0);
        send_conic(32'h10000, 0, 32'h20000, 32'h30000, 32'h40000, 32'h50000);
        send_conic(32'h30000, 0, 32'h10000, 32'h10000, 0, 0);
        send_conic(32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
        send_conic(32'h10000, 32'hffff0000, 32'h10000, 32'h20000, 32'h20000, 1);
        send_conic(32'h20000, 32'h10000, 32'h10000, 0, 32'h10000, 0);
        send_conic(32'h10000, 32'h10000, 32'h20000, 32'h10000, 0, 0);
        send_conic(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff);
        send_conic(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff, 32'h80000000);
        send_conic(32'h7fffffff, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        send_conic(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                   32'hffffffff, 32'hffffffff);
        send_conic(1, 32'h80000000, 32'hffffffff, 1, 1, 32'h80000000);
        send_conic(32'h80000000, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                   32'h80000000);
        send_conic(32'hfffe0000, 0, 32'hffff0000, 32'h10000, 32'h10000, 0);
        send_conic(32'h1, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h7fffffff);
        start <= 1'b0;

        // Let the pipeline drain once
        guard = 0;
        while (pending != 0 && guard < 10 * LATENCY) begin
            @(posedge i_clk);
            guard++;
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            idle_pct = (n < N_RANDOM / 3) ? 25 : (n < 2 * N_RANDOM / 3) ? 88 : 0;
            random_conic();
        end
        start <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 10 * LATENCY) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[conic_canonical_form] OK");
        end else begin
            $display("[conic_canonical_form] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/ccf_pkg.sv
design/ccf_div.sv
design/conic_canonical_form.sv
tb/conic_canonical_form_checker.sv
tb/conic_canonical_form_test.sv
